>>> hw/rtl/dmrp_pkg.sv
// Shared constants and types for the dual motor ramp PWM controller.
// No dependencies; imported by dual_motor_ramp_pwm_controller.
`timescale 1ns / 1ps

package dmrp_pkg;

  // Field widths
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned POWER_W  = 7;
  localparam int unsigned PERIOD_W = 12;
  localparam int unsigned DUTY_W   = 13;
  localparam int unsigned PROD_W   = POWER_W + PERIOD_W;

  // Power limits in percent
  localparam logic [POWER_W-1:0] MAX_POWER = 7'd98;
  localparam logic [POWER_W-1:0] MIN_POWER = 7'd1;
  localparam int unsigned        PERCENT   = 100;

  // Reset value of the PWM period register
  localparam logic [PERIOD_W-1:0] PWM_PERIOD_RESET = 12'd199;

  // Divide by PERCENT through a reciprocal: q = (x * DIV_RECIP) >> DIV_SHIFT.
  // Exact for every x below 2**DIV_SHIFT / 36, well above the largest product.
  localparam int unsigned DIV_SHIFT  = 26;
  localparam int unsigned DIV_RECIP  = ((1 << DIV_SHIFT) + PERCENT - 1) / PERCENT;
  localparam int unsigned RECIP_W    = 20;
  localparam int unsigned QPROD_W    = PROD_W + RECIP_W;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 3'd0,
    CMD_FORWARD    = 3'd1,
    CMD_TURN_LEFT  = 3'd2,
    CMD_TURN_RIGHT = 3'd3,
    CMD_STOP       = 3'd4
  } cmd_t;

endpackage

>>> hw/rtl/dual_motor_ramp_pwm_controller.sv
// Dual motor soft-start PWM controller: ramp state update and duty pipeline.
// Depends on dmrp_pkg for widths, limits, command codes and divider constants.
// A result reaches out_valid through the snapshot, product, quotient and duty stages.
// Throughput: one transaction per cycle; the four-stage pipeline advances as a whole
// and stalls only while a finished result waits on out_ready.
// Reset (rst, synchronous): powers, directions and goal cleared, ramp idle,
// pwm_period back to 199, pipeline emptied.
`timescale 1ns / 1ps

module dual_motor_ramp_pwm_controller
  import dmrp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Configuration
  input  logic                cfg_wr_en,
  input  logic [PERIOD_W-1:0] cfg_wr_data,
  // Input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    command,
  input  logic [POWER_W-1:0]  target_power,
  // Output channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DUTY_W-1:0]   left_duty,
  output logic [DUTY_W-1:0]   right_duty,
  output logic                left_dir,
  output logic                right_dir,
  output logic                busy_res
);

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_UP        = 2'd1,
    PH_TURN_DOWN = 2'd2,
    PH_STOP_DOWN = 2'd3
  } phase_t;

  // Ramp state
  logic [PERIOD_W-1:0] pwm_period;
  logic [POWER_W-1:0]  left_power, right_power;
  logic                left_direction, right_direction;
  phase_t              phase;
  logic [POWER_W-1:0]  goal_power;
  logic                pending_left_dir, pending_right_dir;

  logic [POWER_W-1:0]  left_power_next, right_power_next;
  logic                left_direction_next, right_direction_next;
  phase_t              phase_next;
  logic [POWER_W-1:0]  goal_power_next;
  logic                pending_left_dir_next, pending_right_dir_next;

  // Pipeline registers
  logic                s1_valid, s2_valid, s3_valid;
  logic [POWER_W-1:0]  s1_left_power, s1_right_power;
  logic                s1_left_dir, s1_right_dir, s1_busy;
  logic [PROD_W-1:0]   s2_left_prod, s2_right_prod;
  logic                s2_left_dir, s2_right_dir, s2_busy;
  logic [PERIOD_W-1:0] s3_left_quot, s3_right_quot;
  logic                s3_left_dir, s3_right_dir, s3_busy;

  logic                advance;
  logic                in_accept;
  logic [QPROD_W-1:0]  left_qprod, right_qprod;

  // The whole pipeline moves unless a finished result is held back.
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;
  assign in_accept = in_valid && in_ready;

  // Next ramp state for one transaction.
  always_comb begin
    logic [POWER_W-1:0] goal_clamped;
    logic               both_low_now;
    logic               both_low_dec;
    logic               turn_left_dir;
    logic               turn_right_dir;
    logic [POWER_W-1:0] dec_left, dec_right;

    goal_clamped = (target_power > MAX_POWER) ? MAX_POWER : target_power;
    both_low_now = (left_power <= MIN_POWER) && (right_power <= MIN_POWER);
    dec_left     = (left_power > MIN_POWER) ? left_power - 7'd1 : left_power;
    dec_right    = (right_power > MIN_POWER) ? right_power - 7'd1 : right_power;
    both_low_dec = (dec_left <= MIN_POWER) && (dec_right <= MIN_POWER);
    turn_left_dir  = (command == CMD_TURN_RIGHT);
    turn_right_dir = (command == CMD_TURN_LEFT);

    left_power_next        = left_power;
    right_power_next       = right_power;
    left_direction_next    = left_direction;
    right_direction_next   = right_direction;
    phase_next             = phase;
    goal_power_next        = goal_power;
    pending_left_dir_next  = pending_left_dir;
    pending_right_dir_next = pending_right_dir;

    unique case (command)
      CMD_TICK: begin
        unique case (phase)
          PH_UP: begin
            // Each power steps one toward the goal.
            if (left_power < goal_power) begin
              left_power_next = left_power + 7'd1;
            end else if (left_power > goal_power) begin
              left_power_next = left_power - 7'd1;
            end
            if (right_power < goal_power) begin
              right_power_next = right_power + 7'd1;
            end else if (right_power > goal_power) begin
              right_power_next = right_power - 7'd1;
            end
            phase_next = (left_power_next == goal_power && right_power_next == goal_power)
                         ? PH_IDLE : PH_UP;
          end
          PH_TURN_DOWN, PH_STOP_DOWN: begin
            left_power_next  = dec_left;
            right_power_next = dec_right;
            if (both_low_dec) begin
              if (phase == PH_TURN_DOWN) begin
                // Ramp down done: apply the new directions and ramp toward the goal unless already there.
                left_direction_next  = pending_left_dir;
                right_direction_next = pending_right_dir;
                phase_next = (dec_left == goal_power && dec_right == goal_power)
                             ? PH_IDLE : PH_UP;
              end else begin
                phase_next = PH_IDLE;
              end
            end
          end
          default: begin
          end
        endcase
      end
      CMD_FORWARD: begin
        left_direction_next  = 1'b1;
        right_direction_next = 1'b1;
        goal_power_next      = goal_clamped;
        phase_next = (left_power == goal_clamped && right_power == goal_clamped)
                     ? PH_IDLE : PH_UP;
      end
      CMD_TURN_LEFT, CMD_TURN_RIGHT: begin
        goal_power_next = goal_clamped;
        if (left_direction == turn_left_dir && right_direction == turn_right_dir) begin
          phase_next = (left_power == goal_clamped && right_power == goal_clamped)
                       ? PH_IDLE : PH_UP;
        end else begin
          pending_left_dir_next  = turn_left_dir;
          pending_right_dir_next = turn_right_dir;
          if (both_low_now) begin
            // Already slow enough: switch directions at once.
            left_direction_next  = turn_left_dir;
            right_direction_next = turn_right_dir;
            phase_next = (left_power == goal_clamped && right_power == goal_clamped)
                         ? PH_IDLE : PH_UP;
          end else begin
            phase_next = PH_TURN_DOWN;
          end
        end
      end
      CMD_STOP: begin
        phase_next = both_low_now ? PH_IDLE : PH_STOP_DOWN;
      end
      default: begin
        // Unused codes leave the state alone.
      end
    endcase
  end

  // Ramp state and configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period        <= PWM_PERIOD_RESET;
      left_power        <= '0;
      right_power       <= '0;
      left_direction    <= 1'b0;
      right_direction   <= 1'b0;
      phase             <= PH_IDLE;
      goal_power        <= '0;
      pending_left_dir  <= 1'b0;
      pending_right_dir <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pwm_period <= cfg_wr_data;
      end
      if (in_accept) begin
        left_power        <= left_power_next;
        right_power       <= right_power_next;
        left_direction    <= left_direction_next;
        right_direction   <= right_direction_next;
        phase             <= phase_next;
        goal_power        <= goal_power_next;
        pending_left_dir  <= pending_left_dir_next;
        pending_right_dir <= pending_right_dir_next;
      end
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  // Reciprocal products for the divide by PERCENT.
  assign left_qprod  = QPROD_W'(s2_left_prod) * QPROD_W'(DIV_RECIP);
  assign right_qprod = QPROD_W'(s2_right_prod) * QPROD_W'(DIV_RECIP);

  // Pipeline payload: snapshot, power times period, quotient, duty.
  always_ff @(posedge clk) begin
    logic [PERIOD_W-1:0] left_d, right_d;
    left_d  = s3_left_dir ? pwm_period - s3_left_quot : s3_left_quot;
    right_d = s3_right_dir ? pwm_period - s3_right_quot : s3_right_quot;
    if (advance) begin
      s1_left_power  <= left_power_next;
      s1_right_power <= right_power_next;
      s1_left_dir    <= left_direction_next;
      s1_right_dir   <= right_direction_next;
      s1_busy        <= (phase_next != PH_IDLE);

      s2_left_prod   <= PROD_W'(s1_left_power) * PROD_W'(pwm_period);
      s2_right_prod  <= PROD_W'(s1_right_power) * PROD_W'(pwm_period);
      s2_left_dir    <= s1_left_dir;
      s2_right_dir   <= s1_right_dir;
      s2_busy        <= s1_busy;

      s3_left_quot   <= left_qprod[DIV_SHIFT +: PERIOD_W];
      s3_right_quot  <= right_qprod[DIV_SHIFT +: PERIOD_W];
      s3_left_dir    <= s2_left_dir;
      s3_right_dir   <= s2_right_dir;
      s3_busy        <= s2_busy;

      // Twice the duty minus one, with zero duty held at zero.
      left_duty  <= (left_d == '0) ? '0 : {left_d, 1'b0} - DUTY_W'(1);
      right_duty <= (right_d == '0) ? '0 : {right_d, 1'b0} - DUTY_W'(1);
      left_dir   <= s3_left_dir;
      right_dir  <= s3_right_dir;
      busy_res   <= s3_busy;
    end
  end

  // Powers never leave the clamped range.
  a_power_range: assert property (@(posedge clk) disable iff (rst)
    left_power <= MAX_POWER && right_power <= MAX_POWER)
    else $error("motor power above limit");

  // A tick while idle leaves both powers unchanged.
  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    (in_accept && command == CMD_TICK && phase == PH_IDLE)
    |=> $stable(left_power) && $stable(right_power))
    else $error("power moved on an idle tick");

  // A ramp down step never raises a power.
  a_down_step: assert property (@(posedge clk) disable iff (rst)
    (in_accept && command == CMD_TICK && (phase == PH_TURN_DOWN || phase == PH_STOP_DOWN))
    |=> left_power <= $past(left_power) && right_power <= $past(right_power))
    else $error("power rose during ramp down");

  // Forward drives both motors forward.
  a_forward_dirs: assert property (@(posedge clk) disable iff (rst)
    (in_accept && command == CMD_FORWARD) |=> left_direction && right_direction)
    else $error("forward did not set both directions");

  // A stalled pipeline keeps its quotient stage occupied.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!advance && s3_valid) |=> s3_valid)
    else $error("pipeline stage lost while stalled");

endmodule
